/* design/mstt_pkg.sv */
// Package with the transaction types and codes of the multi-slot timeout table.
package mstt_pkg;

  localparam logic [2:0] ACT_REGISTER   = 3'd0;
  localparam logic [2:0] ACT_TICK       = 3'd1;
  localparam logic [2:0] ACT_REMOVE_ID  = 3'd2;
  localparam logic [2:0] ACT_REMOVE_REP = 3'd3;
  localparam logic [2:0] ACT_CLEAR_ALL  = 3'd4;

  localparam logic [2:0] KIND_WAKE  = 3'd0;
  localparam logic [2:0] KIND_DROP  = 3'd1;
  localparam logic [2:0] KIND_REG   = 3'd2;
  localparam logic [2:0] KIND_FULL  = 3'd3;
  localparam logic [2:0] KIND_COUNT = 3'd4;

  localparam logic REPEAT_MARK = 1'b1;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] now_ticks;
    logic [31:0] wait_ticks;
    logic        repeat_req;
    logic [15:0] timer_id;
    logic [15:0] user_tag;
  } mstt_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] event_id;
    logic [15:0] event_tag;
    logic [3:0]  removed_count;
    logic        last;
  } mstt_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_READ,
    ST_EVAL,
    ST_DROP,
    ST_COUNT
  } mstt_state_t;

endpackage

/* design/multi_slot_timeout_table_core.sv */
// Top level of the multi-slot timeout table: slot memory and walking sequencer.
//
// Usage: present an input transaction on in_item with start high while busy is low.
// Every result appears on out_item for one cycle with out_valid high; out_item.last
// marks the final result of the transaction. The receiver cannot stall the block
// and must take each result as it appears.
// Register keeps busy high while each held timer moves the slot memory down one
// place, then gives the result. A full table gives its result without moving any
// timer. Tick and the removals walk the held timers one slot at a time (memory
// read, then compare and write back), with a drop step for each drop event and a
// closing step: the count result for removals, or for a tick with results the
// held back final result, which waits until the walk shows that nothing follows it.
// Timers are kept packed in the slot memory, newest at slot 0.
// An unknown action or a tick on an empty table gives no result and leaves busy
// low. A tick that finds nothing due still walks the table with busy high.
// Reset clears the timer count and the id counter; the slot memory is not
// cleared since only entries below the count are ever read.
module multi_slot_timeout_table_core
  import mstt_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mstt_in_t  in_item,
  output logic      out_valid,
  output mstt_out_t out_item
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] st;
    logic [31:0] wt;
    logic        rep;
    logic [15:0] tag;
  } slot_t;

  slot_t mem [SLOTS];
  slot_t rd_r;
  logic  we;
  logic [IW-1:0] wa, ra;
  slot_t wd;

  mstt_state_t state_r, state_nxt;
  mstt_in_t    req_r;
  logic [CW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt, keep_r, keep_nxt;
  logic [15:0] nid_r, nid_nxt;
  logic [3:0]  nrem_r, nrem_nxt;
  logic        hit;
  logic        emitted_r, emitted_nxt;
  mstt_out_t   hold_r, hold_nxt;
  logic [31:0] diff;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign diff = req_r.now_ticks - rd_r.st;

  always_comb begin
    hit = 1'b0;
    case (req_r.action)
      ACT_TICK:       hit = (diff >= rd_r.wt);
      ACT_REMOVE_ID:  hit = (rd_r.id == req_r.timer_id);
      ACT_REMOVE_REP: hit = (rd_r.rep == req_r.repeat_req);
      default:        hit = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_item.action)
            ACT_REGISTER: state_nxt = ST_SHIFT;
            ACT_TICK, ACT_REMOVE_ID, ACT_REMOVE_REP, ACT_CLEAR_ALL:
              state_nxt = (cnt_r == '0) ? ((in_item.action == ACT_TICK) ? ST_IDLE : ST_COUNT)
                                        : ST_READ;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SHIFT: begin
        if (cnt_r == CW'(SLOTS) || idx_r == '0) state_nxt = ST_IDLE;
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (hit && !(req_r.action == ACT_TICK && rd_r.rep == REPEAT_MARK)) begin
          state_nxt = ST_DROP;
        end else if (idx_r + 1'b1 < cnt_r) begin
          state_nxt = ST_READ;
        end else if (req_r.action == ACT_TICK) begin
          state_nxt = (emitted_r || hit) ? ST_COUNT : ST_IDLE;
        end else begin
          state_nxt = ST_COUNT;
        end
      end
      ST_DROP: begin
        if (idx_r < cnt_r) state_nxt = ST_READ;
        else state_nxt = ST_COUNT;
      end
      ST_COUNT: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    keep_nxt    = keep_r;
    nid_nxt     = nid_r;
    nrem_nxt    = nrem_r;
    emitted_nxt = emitted_r;
    hold_nxt    = hold_r;
    we          = 1'b0;
    wa          = '0;
    wd          = rd_r;
    ra          = idx_r[IW-1:0];
    out_valid   = 1'b0;
    out_item    = '0;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt     = cnt_r;
        keep_nxt    = '0;
        nrem_nxt    = '0;
        emitted_nxt = 1'b0;
        if (start && in_item.action != ACT_REGISTER) begin
          idx_nxt = '0;
        end
        if (start && in_item.action == ACT_REGISTER && cnt_r != '0 &&
            cnt_r != CW'(SLOTS)) begin
          ra = IW'(cnt_r - 1'b1);
        end
      end
      ST_SHIFT: begin
        if (cnt_r == CW'(SLOTS)) begin
          out_valid = 1'b1;
          out_item.kind = KIND_FULL;
          out_item.event_tag = req_r.user_tag;
          out_item.last = 1'b1;
        end else if (idx_r != '0) begin
          we = 1'b1;
          wa = idx_r[IW-1:0];
          wd = rd_r;
          idx_nxt = idx_r - 1'b1;
          if (idx_r > CW'(1)) ra = IW'(idx_r - 2'd2);
        end else begin
          we = 1'b1;
          wa = '0;
          wd = '{id: nid_r, st: req_r.now_ticks, wt: req_r.wait_ticks,
                 rep: req_r.repeat_req, tag: req_r.user_tag};
          cnt_nxt = cnt_r + 1'b1;
          nid_nxt = nid_r + 16'd1;
          out_valid = 1'b1;
          out_item.kind = KIND_REG;
          out_item.event_id = nid_r;
          out_item.event_tag = req_r.user_tag;
          out_item.last = 1'b1;
        end
      end
      ST_READ: ;
      ST_EVAL: begin
        idx_nxt = idx_r + 1'b1;
        if (req_r.action == ACT_TICK) begin
          if (hit) begin
            out_valid = emitted_r;
            out_item = hold_r;
            hold_nxt = '0;
            hold_nxt.kind = KIND_WAKE;
            hold_nxt.event_id = rd_r.id;
            hold_nxt.event_tag = rd_r.tag;
            emitted_nxt = 1'b1;
          end
          if (hit && rd_r.rep != REPEAT_MARK) begin
            cnt_nxt = cnt_r;
          end else begin
            we = 1'b1;
            wa = keep_r[IW-1:0];
            wd = rd_r;
            if (hit) wd.st = req_r.now_ticks;
            keep_nxt = keep_r + 1'b1;
            if (idx_r + 1'b1 >= cnt_r) cnt_nxt = keep_r + 1'b1;
          end
        end else if (!hit) begin
          we = 1'b1;
          wa = keep_r[IW-1:0];
          wd = rd_r;
          keep_nxt = keep_r + 1'b1;
          if (idx_r + 1'b1 >= cnt_r) cnt_nxt = keep_r + 1'b1;
        end
      end
      ST_DROP: begin
        out_valid = 1'b1;
        if (req_r.action == ACT_TICK) begin
          out_item = hold_r;
          hold_nxt = '0;
          hold_nxt.kind = KIND_DROP;
          hold_nxt.event_id = rd_r.id;
          hold_nxt.event_tag = rd_r.tag;
        end else begin
          out_item.kind = KIND_DROP;
          out_item.event_id = rd_r.id;
          out_item.event_tag = rd_r.tag;
        end
        emitted_nxt = 1'b1;
        if (nrem_r != 4'd15) nrem_nxt = nrem_r + 4'd1;
        if (idx_r >= cnt_r) cnt_nxt = keep_r;
      end
      ST_COUNT: begin
        out_valid = 1'b1;
        if (req_r.action == ACT_TICK) begin
          out_item = hold_r;
        end else begin
          out_item.kind = KIND_COUNT;
          out_item.removed_count = nrem_r;
        end
        out_item.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      nid_r     <= '0;
      idx_r     <= '0;
      keep_r    <= '0;
      nrem_r    <= '0;
      emitted_r <= 1'b0;
      hold_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      nid_r     <= nid_nxt;
      idx_r     <= idx_nxt;
      keep_r    <= keep_nxt;
      nrem_r    <= nrem_nxt;
      emitted_r <= emitted_nxt;
      hold_r    <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) req_r <= in_item;
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* test/tb_multi_slot_timeout_table_core.sv */
// Self-checking testbench of the multi-slot timeout table core with a scoreboard class.
module tb_multi_slot_timeout_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mstt_pkg::*;

  localparam int SLOTS = 8;
  localparam int CYCLE_LIMIT = 400000;

  class timer_table_scoreboard;
    logic [3:0]  count;
    logic [15:0] next_id;
    logic [15:0] ids [SLOTS];
    logic [31:0] starts [SLOTS];
    logic [31:0] waits [SLOTS];
    logic        reps [SLOTS];
    logic [15:0] tags [SLOTS];
    mstt_out_t   pending [$];
    int          errors;

    function new();
      count = 0;
      next_id = 0;
      errors = 0;
    endfunction

    function void push_event(logic [2:0] kind, logic [15:0] id, logic [15:0] tag,
                             logic [3:0] cnt);
      mstt_out_t r;
      r.kind = kind;
      r.event_id = id;
      r.event_tag = tag;
      r.removed_count = cnt;
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    function void copy_slot(int dst, int src);
      ids[dst] = ids[src];
      starts[dst] = starts[src];
      waits[dst] = waits[src];
      reps[dst] = reps[src];
      tags[dst] = tags[src];
    endfunction

    function void note_input(mstt_in_t t);
      int before_n;
      int keep;
      int dropped;
      bit hit;
      bit gone;
      before_n = pending.size();
      keep = 0;
      dropped = 0;
      case (t.action)
        ACT_REGISTER: begin
          if (count >= SLOTS) begin
            push_event(KIND_FULL, 16'd0, t.user_tag, 4'd0);
          end else begin
            for (int i = count; i > 0; i--) copy_slot(i, i - 1);
            ids[0] = next_id;
            starts[0] = t.now_ticks;
            waits[0] = t.wait_ticks;
            reps[0] = t.repeat_req;
            tags[0] = t.user_tag;
            count++;
            push_event(KIND_REG, next_id, t.user_tag, 4'd0);
            next_id++;
          end
        end
        ACT_TICK: begin
          for (int i = 0; i < count; i++) begin
            gone = 0;
            if (32'(t.now_ticks - starts[i]) >= waits[i]) begin
              push_event(KIND_WAKE, ids[i], tags[i], 4'd0);
              if (reps[i] == REPEAT_MARK) begin
                starts[i] = t.now_ticks;
              end else begin
                push_event(KIND_DROP, ids[i], tags[i], 4'd0);
                gone = 1;
              end
            end
            if (!gone) begin
              if (keep != i) copy_slot(keep, i);
              keep++;
            end
          end
          count = keep;
        end
        ACT_REMOVE_ID, ACT_REMOVE_REP, ACT_CLEAR_ALL: begin
          for (int i = 0; i < count; i++) begin
            if (t.action == ACT_CLEAR_ALL) hit = 1;
            else if (t.action == ACT_REMOVE_ID) hit = (ids[i] == t.timer_id);
            else hit = (reps[i] == t.repeat_req);
            if (hit) begin
              push_event(KIND_DROP, ids[i], tags[i], 4'd0);
              dropped++;
            end else begin
              if (keep != i) copy_slot(keep, i);
              keep++;
            end
          end
          count = keep;
          push_event(KIND_COUNT, 16'd0, 16'd0, dropped > 15 ? 4'd15 : 4'(dropped));
        end
        default: ;
      endcase
      if (pending.size() > before_n) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(mstt_out_t got);
      mstt_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d", got.kind, got.event_id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, got.kind);
        errors++;
      end
      if (got.event_id !== e.event_id) begin
        $error("event_id: expected %0d, actual %0d", e.event_id, got.event_id);
        errors++;
      end
      if (got.event_tag !== e.event_tag) begin
        $error("event_tag: expected %0d, actual %0d", e.event_tag, got.event_tag);
        errors++;
      end
      if (got.removed_count !== e.removed_count) begin
        $error("removed_count: expected %0d, actual %0d", e.removed_count,
               got.removed_count);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  mstt_in_t  in_item;
  logic      out_valid;
  mstt_out_t out_item;
  int        cycles;
  logic [31:0] clock_now;
  timer_table_scoreboard timers;

  multi_slot_timeout_table_core #(.SLOTS(SLOTS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) timers.check_result(out_item);
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The busy value seen right after an edge is the one that edge sampled, so the
  // loop leaves at the edge that accepted the transaction. Start stays high until
  // the next call, which lowers it only when it idles first.
  task automatic send_item(mstt_in_t t, bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 18) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    timers.note_input(t);
  endtask

  function automatic mstt_in_t make_item(logic [2:0] act, logic [31:0] now,
                                         logic [31:0] wt, logic rep,
                                         logic [15:0] id, logic [15:0] tag);
    mstt_in_t t;
    t.action = act;
    t.now_ticks = now;
    t.wait_ticks = wt;
    t.repeat_req = rep;
    t.timer_id = id;
    t.user_tag = tag;
    return t;
  endfunction

  function automatic logic [31:0] rand_wait();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (timers.pending.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 6) @(posedge clk);
  endtask

  initial begin
    mstt_in_t t;
    int pick;
    timers = new();
    cycles = 0;
    clock_now = 32'hFFFF_FFF0;
    start = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item(ACT_TICK, 32'd0, 32'd0, 1'b0, 16'd0, 16'd0), 0);
    send_item(make_item(ACT_CLEAR_ALL, 32'd0, 32'd0, 1'b0, 16'd0, 16'd0), 0);
    send_item(make_item(ACT_REGISTER, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0, 16'hFFFF), 0);
    send_item(make_item(ACT_REGISTER, 32'h0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'h0), 0);
    send_item(make_item(ACT_REGISTER, 32'hFFFF_FFF0, 32'h20, 1'b1, 16'h0, 16'h5A5A), 0);
    for (int i = 0; i < 6; i++)
      send_item(make_item(ACT_REGISTER, 32'h10, 32'd5, i[0], 16'h0, 16'(i)), 0);
    send_item(make_item(ACT_TICK, 32'h10, 32'h0, 1'b0, 16'h0, 16'h0), 0);
    send_item(make_item(ACT_TICK, 32'h15, 32'h0, 1'b1, 16'hFFFF, 16'hFFFF), 0);
    send_item(make_item(ACT_REMOVE_ID, 32'h0, 32'h0, 1'b0, 16'd2, 16'h0), 0);
    send_item(make_item(ACT_REMOVE_ID, 32'h0, 32'h0, 1'b0, 16'hFFFF, 16'h0), 0);
    send_item(make_item(ACT_REMOVE_REP, 32'h0, 32'h0, 1'b0, 16'h0, 16'h0), 0);
    send_item(make_item(ACT_REMOVE_REP, 32'h0, 32'h0, 1'b1, 16'h0, 16'h0), 0);
    send_item(make_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF), 0);
    send_item(make_item(3'd7, 32'h0, 32'h0, 1'b0, 16'h0, 16'h0), 0);
    send_item(make_item(ACT_CLEAR_ALL, 32'h0, 32'h0, 1'b0, 16'h0, 16'h0), 0);
    drain();

    for (int n = 0; n < 290; n++) begin
      if (n == 150) drain();
      clock_now = clock_now + $urandom_range(0, 30);
      pick = $urandom_range(0, 99);
      t.now_ticks = ($urandom_range(0, 19) == 0) ? $urandom : clock_now;
      t.wait_ticks = rand_wait();
      t.repeat_req = $urandom_range(0, 1);
      t.user_tag = $urandom;
      t.timer_id = (timers.count != 0 && $urandom_range(0, 2) != 0)
                   ? timers.ids[$urandom_range(0, timers.count - 1)] : 16'($urandom);
      if (pick < 40) t.action = ACT_REGISTER;
      else if (pick < 75) t.action = ACT_TICK;
      else if (pick < 87) t.action = ACT_REMOVE_ID;
      else if (pick < 94) t.action = ACT_REMOVE_REP;
      else if (pick < 98) t.action = ACT_CLEAR_ALL;
      else t.action = 3'($urandom_range(5, 7));
      send_item(t, $urandom_range(0, 4) != 0 && (n / 40) % 3 != 1);
    end

    drain();
    if (timers.errors == 0 && timers.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* filelist.f */
design/mstt_pkg.sv
design/multi_slot_timeout_table_core.sv
test/tb_multi_slot_timeout_table_core.sv
